FILE: rtl/tft_pkg.sv
// Shared widths for the triangle tangent block.
package tft_pkg;
   localparam int SUM_WIDTH  = 64;
   localparam int ROOT_WIDTH = 32;
   localparam int MAG_BITS   = 31;
   localparam int NORM_LOW   = 30;
endpackage

FILE: rtl/tft_mul.sv
// Shared signed multiplier with a registered product.
module tft_mul
   import tft_pkg::*;
#(
   parameter int A_WIDTH = 33,
   parameter int B_WIDTH = 32
) (
   input  logic                                clock,
   input  logic signed [A_WIDTH-1:0]           mul_a,
   input  logic signed [B_WIDTH-1:0]           mul_b,
   output logic signed [A_WIDTH+B_WIDTH-1:0]   mul_p
);
   logic signed [A_WIDTH+B_WIDTH-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;
endmodule

FILE: rtl/tft_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module tft_isqrt
   import tft_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_WIDTH-1:0]   radicand,
   output logic                   done,
   output logic [ROOT_WIDTH-1:0]  root
);
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [SUM_WIDTH-1:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in, trial;

   always_comb begin
      trial   = r_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = radicand;
         r_in    = '0;
         bit_in  = SUM_WIDTH'(1) << (SUM_WIDTH - 2);
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_WIDTH-1:0];
endmodule

FILE: rtl/tft_div.sv
// Restoring divider, one quotient bit per cycle.
module tft_div
   import tft_pkg::*;
#(
   parameter int Q_WIDTH = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_WIDTH-1:0]   dividend,
   input  logic [ROOT_WIDTH-1:0]  divisor,
   output logic                   done,
   output logic [Q_WIDTH-1:0]     quotient
);
   localparam int CW = $clog2(Q_WIDTH + 1);

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [SUM_WIDTH-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [Q_WIDTH-1:0]   q_ff, q_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(Q_WIDTH - 1);
         rem_in  = dividend;
         dsh_in  = SUM_WIDTH'(divisor) << (Q_WIDTH - 1);
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[Q_WIDTH-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[Q_WIDTH-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

FILE: rtl/triangle_tangent_from_uv_top.sv
// Top level: per-triangle tangent from positions and texture coordinates.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, pos_x/y/z, tex_u/v     | vertex in
//   rsp     | rsp_valid/ready, tangent_x/y/z, flags   | tangent out (3 per triangle)
//
// Corners one and two are only stored. The third corner runs a sequencer
// over one shared multiplier (8 products, then 3 squares), a one-bit-per-cycle
// normalizing shifter, a square root and three divides, then gives three
// results. Degenerate triangles skip the squares, root and divides.
// Reset is synchronous and clears the corner count and sequencer.
// Request ready is low from the third corner until its last result is taken.
module triangle_tangent_from_uv_top
   import tft_pkg::*;
#(
   parameter int POS_WIDTH = 24,
   parameter int UV_WIDTH  = 16,
   parameter int OUT_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [POS_WIDTH-1:0] req_pos_x,
   input  logic signed [POS_WIDTH-1:0] req_pos_y,
   input  logic signed [POS_WIDTH-1:0] req_pos_z,
   input  logic signed [UV_WIDTH-1:0]  req_tex_u,
   input  logic signed [UV_WIDTH-1:0]  req_tex_v,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_WIDTH-1:0] rsp_tangent_x,
   output logic signed [OUT_WIDTH-1:0] rsp_tangent_y,
   output logic signed [OUT_WIDTH-1:0] rsp_tangent_z,
   output logic                        rsp_degenerate,
   output logic                        rsp_last_of_triangle
);
   localparam int DPW  = POS_WIDTH + 1;
   localparam int DUW  = UV_WIDTH + 1;
   localparam int TW   = POS_WIDTH + UV_WIDTH + 3;
   localparam int DETW = 2 * UV_WIDTH + 3;
   localparam int MW   = (TW > 32) ? TW : 32;
   localparam int AW   = (DPW > 32) ? DPW : 32;
   localparam int BW   = 32;
   localparam int PRW  = AW + BW;
   localparam int QW   = OUT_WIDTH - 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_SIGN = 3'd2;
   localparam logic [2:0] S_NORM = 3'd3;
   localparam logic [2:0] S_SQ   = 3'd4;
   localparam logic [2:0] S_ROOT = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] idx_ff, idx_in, corner_ff, corner_in;

   // held corners, written before read within a triangle
   logic signed [POS_WIDTH-1:0] hpos_ff [2][3];
   logic signed [UV_WIDTH-1:0]  huv_ff  [2][2];

   logic signed [DUW-1:0]  du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [DPW-1:0]  dp1_ff [3];
   logic signed [DPW-1:0]  dp2_ff [3];
   logic signed [PRW-1:0]  acc_ff, prod, diff;
   logic signed [DETW-1:0] det_ff;
   logic signed [TW-1:0]   t_ff [3];
   logic [MW-1:0]          m_ff [3];
   logic [MW-1:0]          mx;
   logic [2:0]             neg_ff;
   logic                   degen_ff;
   logic [SUM_WIDTH-1:0]   sum_ff, div_num;
   logic [ROOT_WIDTH-1:0]  len_ff, root;
   logic signed [OUT_WIDTH-1:0] res_ff [3];
   logic [QW-1:0]          quo;
   logic [OUT_WIDTH-1:0]   quo_ext;
   logic signed [AW-1:0]   mul_a;
   logic signed [BW-1:0]   mul_b;
   logic [MAG_BITS-1:0]    sq_op;
   logic                   root_start, root_done, div_start, div_done;
   logic                   req_fire, rsp_fire;
   logic [3:0]             issue;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign diff     = acc_ff - prod;
   assign issue    = step_ff - 4'd1;

   // operand select for the shared multiplier
   always_comb begin
      sq_op = '0;
      case (step_ff[1:0])
         2'd0:    sq_op = m_ff[0][MAG_BITS-1:0];
         2'd1:    sq_op = m_ff[1][MAG_BITS-1:0];
         2'd2:    sq_op = m_ff[2][MAG_BITS-1:0];
         default: sq_op = '0;
      endcase
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SQ) begin
         mul_a = AW'($signed({1'b0, sq_op}));
         mul_b = BW'($signed({1'b0, sq_op}));
      end else begin
         case (step_ff[2:0])
            3'd0: begin mul_a = AW'(du1_ff);    mul_b = BW'(dv2_ff); end
            3'd1: begin mul_a = AW'(dv1_ff);    mul_b = BW'(du2_ff); end
            3'd2: begin mul_a = AW'(dp1_ff[0]); mul_b = BW'(dv2_ff); end
            3'd3: begin mul_a = AW'(dp2_ff[0]); mul_b = BW'(dv1_ff); end
            3'd4: begin mul_a = AW'(dp1_ff[1]); mul_b = BW'(dv2_ff); end
            3'd5: begin mul_a = AW'(dp2_ff[1]); mul_b = BW'(dv1_ff); end
            3'd6: begin mul_a = AW'(dp1_ff[2]); mul_b = BW'(dv2_ff); end
            3'd7: begin mul_a = AW'(dp2_ff[2]); mul_b = BW'(dv1_ff); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   tft_mul #(.A_WIDTH(AW), .B_WIDTH(BW)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (prod)
   );

   assign root_start = (state_ff == S_ROOT) && (step_ff == 4'd0);
   assign div_start  = (state_ff == S_DIV) && (step_ff == 4'd0);

   tft_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_ff),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      div_num = '0;
      case (idx_ff)
         2'd0:    div_num = SUM_WIDTH'(m_ff[0][MAG_BITS-1:0]) << (OUT_WIDTH - 2);
         2'd1:    div_num = SUM_WIDTH'(m_ff[1][MAG_BITS-1:0]) << (OUT_WIDTH - 2);
         2'd2:    div_num = SUM_WIDTH'(m_ff[2][MAG_BITS-1:0]) << (OUT_WIDTH - 2);
         default: div_num = '0;
      endcase
      div_num = div_num + SUM_WIDTH'(len_ff >> 1);
   end

   tft_div #(.Q_WIDTH(QW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign quo_ext = OUT_WIDTH'(quo);

   // largest magnitude for the normalizing shift
   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) mx = m_ff[1];
      if (m_ff[2] > mx) mx = m_ff[2];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      corner_in = corner_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (corner_ff < 2'd2) begin
                  corner_in = corner_ff + 2'd1;
               end else begin
                  corner_in = 2'd0;
                  step_in   = 4'd0;
                  state_in  = S_MUL;
               end
            end
         end
         S_MUL: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd8) state_in = S_SIGN;
         end
         S_SIGN: begin
            step_in = 4'd0;
            idx_in  = 2'd0;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (degen_ff) begin
               state_in = S_OUT;
            end else if (mx[MW-1:NORM_LOW] != '0 && mx[MW-1:NORM_LOW+1] == '0) begin
               state_in = S_SQ;
               step_in  = 4'd0;
            end
         end
         S_SQ: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd3) begin
               state_in = S_ROOT;
               step_in  = 4'd0;
            end
         end
         S_ROOT: begin
            step_in = 4'd1;
            if (root_done) begin
               state_in = S_DIV;
               step_in  = 4'd0;
               idx_in   = 2'd0;
            end
         end
         S_DIV: begin
            step_in = 4'd1;
            if (div_done) begin
               step_in = 4'd0;
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = S_OUT;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= 4'd0;
         idx_ff    <= 2'd0;
         corner_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         idx_ff    <= idx_in;
         corner_ff <= corner_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_fire) begin
         if (corner_ff < 2'd2) begin
            hpos_ff[corner_ff[0]][0] <= req_pos_x;
            hpos_ff[corner_ff[0]][1] <= req_pos_y;
            hpos_ff[corner_ff[0]][2] <= req_pos_z;
            huv_ff[corner_ff[0]][0]  <= req_tex_u;
            huv_ff[corner_ff[0]][1]  <= req_tex_v;
         end else begin
            du1_ff    <= DUW'(huv_ff[1][0]) - DUW'(huv_ff[0][0]);
            dv1_ff    <= DUW'(huv_ff[1][1]) - DUW'(huv_ff[0][1]);
            du2_ff    <= DUW'(req_tex_u) - DUW'(huv_ff[0][0]);
            dv2_ff    <= DUW'(req_tex_v) - DUW'(huv_ff[0][1]);
            dp1_ff[0] <= DPW'(hpos_ff[1][0]) - DPW'(hpos_ff[0][0]);
            dp1_ff[1] <= DPW'(hpos_ff[1][1]) - DPW'(hpos_ff[0][1]);
            dp1_ff[2] <= DPW'(hpos_ff[1][2]) - DPW'(hpos_ff[0][2]);
            dp2_ff[0] <= DPW'(req_pos_x) - DPW'(hpos_ff[0][0]);
            dp2_ff[1] <= DPW'(req_pos_y) - DPW'(hpos_ff[0][1]);
            dp2_ff[2] <= DPW'(req_pos_z) - DPW'(hpos_ff[0][2]);
         end
      end
      // consume the product issued in the cycle before
      if (state_ff == S_MUL && step_ff != 4'd0) begin
         if (!issue[0]) begin
            acc_ff <= prod;
         end else begin
            case (issue[2:1])
               2'd0:    det_ff  <= DETW'(diff);
               2'd1:    t_ff[0] <= TW'(diff);
               2'd2:    t_ff[1] <= TW'(diff);
               2'd3:    t_ff[2] <= TW'(diff);
               default: det_ff  <= DETW'(diff);
            endcase
         end
      end
      if (state_ff == S_SIGN) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[i]   <= MW'(t_ff[i][TW-1] ? TW'(-t_ff[i]) : TW'(t_ff[i]));
            neg_ff[i] <= t_ff[i][TW-1] ^ det_ff[DETW-1];
            res_ff[i] <= '0;
         end
         degen_ff <= (det_ff == '0) ||
                     (t_ff[0] == '0 && t_ff[1] == '0 && t_ff[2] == '0);
         sum_ff   <= '0;
      end
      // normalize one bit per cycle toward [2^30, 2^31)
      if (state_ff == S_NORM && !degen_ff) begin
         if (mx[MW-1:NORM_LOW] == '0) begin
            for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
         end else if (mx[MW-1:NORM_LOW+1] != '0) begin
            for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
         end
      end
      if (state_ff == S_SQ && step_ff != 4'd0) begin
         sum_ff <= sum_ff + prod[SUM_WIDTH-1:0];
      end
      if (state_ff == S_ROOT && root_done) begin
         len_ff <= root;
      end
      if (state_ff == S_DIV && div_done) begin
         case (idx_ff)
            2'd0:    res_ff[0] <= neg_ff[0] ? -quo_ext : quo_ext;
            2'd1:    res_ff[1] <= neg_ff[1] ? -quo_ext : quo_ext;
            2'd2:    res_ff[2] <= neg_ff[2] ? -quo_ext : quo_ext;
            default: res_ff[0] <= res_ff[0];
         endcase
      end
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_tangent_x        = res_ff[0];
   assign rsp_tangent_y        = res_ff[1];
   assign rsp_tangent_z        = res_ff[2];
   assign rsp_degenerate       = degen_ff;
   assign rsp_last_of_triangle = (idx_ff == 2'd2);

   // never take a request while results are pending
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request taken while results pending");
   // a degenerate triangle always gives a zero vector
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
      (rsp_tangent_x == '0 && rsp_tangent_y == '0 && rsp_tangent_z == '0))
      else $error("degenerate result not zero");
   // third corner restarts the corner count
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && corner_ff == 2'd2) |=> (corner_ff == 2'd0 && !req_ready))
      else $error("corner count not cleared on third corner");
   // the last copy ends the burst of results
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_of_triangle) |=> (!rsp_valid && req_ready))
      else $error("results continue past last copy");
endmodule
